// ===== src/ftb_pkg.sv =====
// Shared types, register codes and byte-multiply helpers for the fragment back end.
package ftb_pkg;

    typedef struct packed {
        logic [31:0] texel_color;
        logic [7:0]  vertex_red;
        logic [7:0]  vertex_green;
        logic [7:0]  vertex_blue;
        logic [7:0]  vertex_alpha;
        logic [23:0] fragment_depth;
        logic [31:0] dest_color;
        logic [23:0] dest_depth;
    } t_in_req;

    typedef struct packed {
        logic        alpha_killed;
        logic        depth_killed;
        logic        depth_write_enable;
        logic [23:0] new_depth;
        logic        color_write_enable;
        logic [31:0] new_color;
    } t_out_res;

    typedef struct packed {
        logic [2:0]  alpha_compare_first;
        logic [2:0]  alpha_compare_second;
        logic [1:0]  alpha_join;
        logic [15:0] alpha_references;
        logic [4:0]  depth_control;
        logic [1:0]  blend_mode;
        logic        alpha_combine_enable;
        logic [47:0] alpha_combine_corners;
    } t_cfg;

    typedef struct packed {
        logic [31:0] src_color;
        logic [31:0] dest_color;
        logic [23:0] fragment_depth;
        logic [23:0] dest_depth;
    } t_frag;

    localparam logic [2:0] REG_ALPHA_CMP_FIRST  = 3'd0;
    localparam logic [2:0] REG_ALPHA_CMP_SECOND = 3'd1;
    localparam logic [2:0] REG_ALPHA_JOIN       = 3'd2;
    localparam logic [2:0] REG_ALPHA_REFS       = 3'd3;
    localparam logic [2:0] REG_DEPTH_CONTROL    = 3'd4;
    localparam logic [2:0] REG_BLEND_MODE       = 3'd5;
    localparam logic [2:0] REG_COMBINE_ENABLE   = 3'd6;
    localparam logic [2:0] REG_COMBINE_CORNERS  = 3'd7;

    localparam logic [2:0] CMP_NEVER  = 3'd0;
    localparam logic [2:0] CMP_LT     = 3'd1;
    localparam logic [2:0] CMP_EQ     = 3'd2;
    localparam logic [2:0] CMP_LE     = 3'd3;
    localparam logic [2:0] CMP_GT     = 3'd4;
    localparam logic [2:0] CMP_NE     = 3'd5;
    localparam logic [2:0] CMP_GE     = 3'd6;
    localparam logic [2:0] CMP_ALWAYS = 3'd7;

    localparam logic [1:0] LOGIC_AND  = 2'd0;
    localparam logic [1:0] LOGIC_OR   = 2'd1;
    localparam logic [1:0] LOGIC_XOR  = 2'd2;
    localparam logic [1:0] LOGIC_XNOR = 2'd3;

    localparam logic [1:0] BLEND_OPAQUE = 2'd0;
    localparam logic [1:0] BLEND_ADD    = 2'd1;
    localparam logic [1:0] BLEND_OVER   = 2'd2;

    localparam logic [7:0]         BYTE_MAX        = 8'd255;
    localparam logic [15:0]        MUL_ROUND       = 16'd128;
    localparam logic signed [30:0] COMBINE_ROUND   = 31'sd32640;
    localparam logic signed [30:0] COMBINE_SAT     = 31'sd16711680;

    localparam logic [2:0] DEF_ALPHA_CMP     = CMP_ALWAYS;
    localparam logic [4:0] DEF_DEPTH_CONTROL = 5'd7;
    localparam logic [1:0] DEF_BLEND_MODE    = BLEND_OVER;

    function automatic logic cmp_sel(input logic [2:0] fn, input logic lt, input logic eq);
        logic res;
        unique case (fn)
            CMP_NEVER:  res = 1'b0;
            CMP_LT:     res = lt;
            CMP_EQ:     res = eq;
            CMP_LE:     res = lt | eq;
            CMP_GT:     res = ~(lt | eq);
            CMP_NE:     res = ~eq;
            CMP_GE:     res = ~lt;
            CMP_ALWAYS: res = 1'b1;
            default:    res = 1'b1;
        endcase
        return res;
    endfunction

    // a*b + 128, first half of the exact x*y/255 rounding
    function automatic logic [15:0] prod255(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] p;
        p = {8'b0, a} * {8'b0, b};
        return p + MUL_ROUND;
    endfunction

    // second half: (t + (t >> 8)) >> 8
    function automatic logic [7:0] fin255(input logic [15:0] t);
        logic [16:0] s;
        s = {1'b0, t} + {9'b0, t[15:8]};
        return s[15:8];
    endfunction

endpackage

// ===== src/ftb_regs.sv =====
// APB configuration register file for the fragment back end.
module ftb_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output ftb_pkg::t_cfg       o_cfg
);
    import ftb_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha_compare_first   <= DEF_ALPHA_CMP;
            r_cfg.alpha_compare_second  <= DEF_ALPHA_CMP;
            r_cfg.alpha_join            <= LOGIC_AND;
            r_cfg.alpha_references      <= '0;
            r_cfg.depth_control         <= DEF_DEPTH_CONTROL;
            r_cfg.blend_mode            <= DEF_BLEND_MODE;
            r_cfg.alpha_combine_enable  <= 1'b0;
            r_cfg.alpha_combine_corners <= '0;
        end else if (w_wr) begin
            unique case (paddr[5:3])
                REG_ALPHA_CMP_FIRST:  r_cfg.alpha_compare_first   <= pwdata[2:0];
                REG_ALPHA_CMP_SECOND: r_cfg.alpha_compare_second  <= pwdata[2:0];
                REG_ALPHA_JOIN:       r_cfg.alpha_join            <= pwdata[1:0];
                REG_ALPHA_REFS:       r_cfg.alpha_references      <= pwdata[15:0];
                REG_DEPTH_CONTROL:    r_cfg.depth_control         <= pwdata[4:0];
                REG_BLEND_MODE:       r_cfg.blend_mode            <= pwdata[1:0];
                REG_COMBINE_ENABLE:   r_cfg.alpha_combine_enable  <= pwdata[0];
                REG_COMBINE_CORNERS:  r_cfg.alpha_combine_corners <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_ALPHA_CMP_FIRST:  prdata = {61'b0, r_cfg.alpha_compare_first};
            REG_ALPHA_CMP_SECOND: prdata = {61'b0, r_cfg.alpha_compare_second};
            REG_ALPHA_JOIN:       prdata = {62'b0, r_cfg.alpha_join};
            REG_ALPHA_REFS:       prdata = {48'b0, r_cfg.alpha_references};
            REG_DEPTH_CONTROL:    prdata = {59'b0, r_cfg.depth_control};
            REG_BLEND_MODE:       prdata = {62'b0, r_cfg.blend_mode};
            REG_COMBINE_ENABLE:   prdata = {63'b0, r_cfg.alpha_combine_enable};
            REG_COMBINE_CORNERS:  prdata = {16'b0, r_cfg.alpha_combine_corners};
            default:              prdata = '0;
        endcase
    end

endmodule

// ===== src/ftb_src.sv =====
// Source colour stages: texel modulation and bilinear alpha combine, four register stages.
module ftb_src (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ftb_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    input  ftb_pkg::t_in_req  i_req,
    output logic              o_valid,
    output ftb_pkg::t_frag    o_frag
);
    import ftb_pkg::*;

    logic              r_v1, r_v2, r_v3, r_v4;
    logic [15:0]       r1_tc [4];
    logic [15:0]       r1_w  [4];
    logic [31:0]       r1_dst, r2_dst, r3_dst;
    logic [23:0]       r1_z, r2_z, r3_z, r1_zs, r2_zs, r3_zs;
    logic [31:0]       r2_src, r3_src;
    logic signed [28:0] r2_p [4];
    logic signed [30:0] r3_n;
    t_frag             r_frag;

    logic [7:0]         n_ta, n_va, n_ita, n_iva;
    logic signed [11:0] n_c  [4];
    logic signed [16:0] n_ws [4];
    logic signed [28:0] n_p  [4];
    logic signed [30:0] n_m;
    logic [15:0]        n_k;
    logic [16:0]        n_q;
    logic [7:0]         n_sa;

    always_comb begin
        n_ta  = i_req.texel_color[31:24];
        n_va  = i_req.vertex_alpha;
        n_ita = BYTE_MAX - n_ta;
        n_iva = BYTE_MAX - n_va;
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_c[k]  = $signed(i_cfg.alpha_combine_corners[12*k +: 12]);
            n_ws[k] = $signed({1'b0, r1_w[k]});
            n_p[k]  = n_c[k] * n_ws[k];
        end
    end

    always_comb begin
        n_m = r3_n + COMBINE_ROUND;
        n_k = n_m[23:8];
        n_q = {1'b0, n_k} + {9'b0, n_k[15:8]} + 17'd1;
        if (!i_cfg.alpha_combine_enable) begin
            n_sa = r3_src[31:24];
        end else if (r3_n <= 31'sd0) begin
            n_sa = '0;
        end else if (n_m >= COMBINE_SAT) begin
            n_sa = BYTE_MAX;
        end else begin
            n_sa = n_q[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_tc[0] <= prod255(i_req.texel_color[7:0],   i_req.vertex_red);
        r1_tc[1] <= prod255(i_req.texel_color[15:8],  i_req.vertex_green);
        r1_tc[2] <= prod255(i_req.texel_color[23:16], i_req.vertex_blue);
        r1_tc[3] <= prod255(n_ta, n_va);
        r1_w[0]  <= {8'b0, n_ita} * {8'b0, n_iva};
        r1_w[1]  <= {8'b0, n_ta}  * {8'b0, n_iva};
        r1_w[2]  <= {8'b0, n_ita} * {8'b0, n_va};
        r1_w[3]  <= {8'b0, n_ta}  * {8'b0, n_va};
        r1_dst   <= i_req.dest_color;
        r1_z     <= i_req.fragment_depth;
        r1_zs    <= i_req.dest_depth;

        r2_src   <= {fin255(r1_tc[3]), fin255(r1_tc[2]), fin255(r1_tc[1]), fin255(r1_tc[0])};
        for (int k = 0; k < 4; k++) begin
            r2_p[k] <= n_p[k];
        end
        r2_dst   <= r1_dst;
        r2_z     <= r1_z;
        r2_zs    <= r1_zs;

        r3_n     <= 31'(r2_p[0]) + 31'(r2_p[1]) + 31'(r2_p[2]) + 31'(r2_p[3]);
        r3_src   <= r2_src;
        r3_dst   <= r2_dst;
        r3_z     <= r2_z;
        r3_zs    <= r2_zs;

        r_frag.src_color      <= {n_sa, r3_src[23:0]};
        r_frag.dest_color     <= r3_dst;
        r_frag.fragment_depth <= r3_z;
        r_frag.dest_depth     <= r3_zs;
    end

    assign o_valid = r_v4;
    assign o_frag  = r_frag;

    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##4 o_valid)
        else $error("source stage lost a request");

endmodule

// ===== src/ftb_rop.sv =====
// Alpha test, depth test and blend, two register stages ending in the result register.
module ftb_rop (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ftb_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    input  ftb_pkg::t_frag     i_frag,
    output logic               o_valid,
    output ftb_pkg::t_out_res  o_res
);
    import ftb_pkg::*;

    logic        r_v5, r_v6;
    logic        r5_akill, r5_zkill, r5_zwr;
    logic [31:0] r5_src;
    logic [31:0] r5_dst;
    logic [23:0] r5_z;
    logic [15:0] r5_ts [3];
    logic [15:0] r5_td [4];
    t_out_res    r_res;

    logic [7:0]  n_sa, n_inv, n_ref1, n_ref2;
    logic        n_first, n_second, n_pass, n_zen, n_zok;
    logic [7:0]  n_sa5;
    logic [8:0]  n_sum;
    logic [7:0]  n_col [4];
    logic        n_cwr;
    t_out_res    n_res;

    always_comb begin
        n_sa   = i_frag.src_color[31:24];
        n_inv  = BYTE_MAX - n_sa;
        n_ref1 = i_cfg.alpha_references[7:0];
        n_ref2 = i_cfg.alpha_references[15:8];
        n_first  = cmp_sel(i_cfg.alpha_compare_first,  n_sa < n_ref1, n_sa == n_ref1);
        n_second = cmp_sel(i_cfg.alpha_compare_second, n_sa < n_ref2, n_sa == n_ref2);
        unique case (i_cfg.alpha_join)
            LOGIC_AND:  n_pass = n_first & n_second;
            LOGIC_OR:   n_pass = n_first | n_second;
            LOGIC_XOR:  n_pass = n_first ^ n_second;
            LOGIC_XNOR: n_pass = ~(n_first ^ n_second);
            default:    n_pass = 1'b0;
        endcase
        n_zen = i_cfg.depth_control[0];
        n_zok = cmp_sel(i_cfg.depth_control[4:2],
                        i_frag.fragment_depth < i_frag.dest_depth,
                        i_frag.fragment_depth == i_frag.dest_depth);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v5 <= i_valid;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_akill <= ~n_pass;
        r5_zkill <= n_pass & n_zen & ~n_zok;
        r5_zwr   <= n_pass & n_zen & n_zok & i_cfg.depth_control[1];
        r5_src   <= i_frag.src_color;
        r5_dst   <= i_frag.dest_color;
        r5_z     <= i_frag.fragment_depth;
        for (int c = 0; c < 3; c++) begin
            r5_ts[c] <= prod255(i_frag.src_color[8*c +: 8], n_sa);
        end
        for (int c = 0; c < 4; c++) begin
            r5_td[c] <= prod255(i_frag.dest_color[8*c +: 8], n_inv);
        end
    end

    always_comb begin
        n_sa5 = r5_src[31:24];
        n_sum = '0;
        for (int c = 0; c < 4; c++) begin
            n_col[c] = r5_src[8*c +: 8];
        end
        n_cwr = ~r5_akill & ~r5_zkill;
        if (i_cfg.blend_mode == BLEND_OPAQUE) begin
            for (int c = 0; c < 4; c++) begin
                n_col[c] = r5_src[8*c +: 8];
            end
        end else if (i_cfg.blend_mode == BLEND_ADD) begin
            // saturate each channel
            for (int c = 0; c < 3; c++) begin
                n_sum    = {1'b0, r5_dst[8*c +: 8]} + {1'b0, fin255(r5_ts[c])};
                n_col[c] = n_sum[8] ? BYTE_MAX : n_sum[7:0];
            end
            n_sum    = {1'b0, r5_dst[31:24]} + {1'b0, n_sa5};
            n_col[3] = n_sum[8] ? BYTE_MAX : n_sum[7:0];
        end else if (n_sa5 == '0) begin
            n_cwr = 1'b0;
        end else if (n_sa5 != BYTE_MAX) begin
            for (int c = 0; c < 3; c++) begin
                n_col[c] = fin255(r5_ts[c]) + fin255(r5_td[c]);
            end
            n_col[3] = n_sa5 + fin255(r5_td[3]);
        end
        n_res.alpha_killed       = r5_akill;
        n_res.depth_killed       = r5_zkill;
        n_res.depth_write_enable = r5_zwr;
        n_res.new_depth          = r5_z;
        n_res.color_write_enable = n_cwr;
        n_res.new_color          = n_cwr ? {n_col[3], n_col[2], n_col[1], n_col[0]} : '0;
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_v6;
    assign o_res   = r_res;

    a_kill_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_res.alpha_killed && o_res.depth_killed))
        else $error("alpha and depth kill both set");

    a_cwr_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.color_write_enable |-> !o_res.alpha_killed && !o_res.depth_killed)
        else $error("colour written for a killed fragment");

    a_zwr_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.depth_write_enable |-> !o_res.alpha_killed && !o_res.depth_killed)
        else $error("depth written for a killed fragment");

    a_colour_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.color_write_enable |-> o_res.new_color == '0)
        else $error("colour not cleared when not written");

endmodule

// ===== src/fragment_test_and_blend_unit.sv =====
// Top level of the fragment test and blend unit.
// Path from start to o_res_valid: four source stages, then two test/blend stages.
// Throughput: one fragment per clock; busy is held low and results cannot be stalled.
// Multiplier depth per stage (8x8 or 12x17) sets the stage count.
// Synchronous active-low reset clears all stage valids and loads register defaults.
module fragment_test_and_blend_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ftb_pkg::t_in_req   i_req,
    output logic               o_res_valid,
    output ftb_pkg::t_out_res  o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import ftb_pkg::*;

    t_cfg  w_cfg;
    logic  w_frag_valid;
    t_frag w_frag;

    assign busy = 1'b0;

    ftb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ftb_src u_src (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (start && !busy),
        .i_req   (i_req),
        .o_valid (w_frag_valid),
        .o_frag  (w_frag)
    );

    ftb_rop u_rop (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_frag_valid),
        .i_frag  (w_frag),
        .o_valid (o_res_valid),
        .o_res   (o_res)
    );

endmodule

// ===== tb/tb_fragment_test_and_blend_unit.sv =====
// Self-checking testbench for the fragment test and blend unit: directed and random fragments.
module tb_fragment_test_and_blend_unit;
    import ftb_pkg::*;

    localparam int          CLK_HALF        = 6;
    localparam int          CLK_PERIOD      = 2 * CLK_HALF;
    localparam int          RESET_CYCLES    = 10;
    localparam int          LATENCY         = 6;
    localparam int          DRAIN_LIMIT     = 1000;
    localparam int          WATCHDOG_CYCLES = 100000;
    localparam int          RANDOM_PHASES   = 20;
    localparam int          PHASE_ITEMS     = 47;
    localparam int          CALM_PHASE      = 5;
    localparam int          IDLE_PERCENT    = 20;
    localparam int          MAX_PRINTS      = 40;
    localparam logic [1:0]  BLEND_OVER_ALT  = 2'd3;
    localparam int          DEPTH_TEST_BIT  = 0;
    localparam int          DEPTH_WRITE_BIT = 1;
    localparam logic [23:0] MAX_DEPTH       = 24'hFFFFFF;
    localparam longint      COMBINE_DIV     = 65280;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_req     i_req;
    logic        o_res_valid;
    t_out_res    o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    t_cfg raster_cfg = '{DEF_ALPHA_CMP, DEF_ALPHA_CMP, LOGIC_AND, 16'd0,
                         DEF_DEPTH_CONTROL, DEF_BLEND_MODE, 1'b0, 48'd0};
    t_out_res pending_pixels[$];
    t_out_res expected_pixel;
    int       fragments_sent   = 0;
    int       pixels_checked   = 0;
    int       settings_applied = 0;
    int       fault_count      = 0;

    fragment_test_and_blend_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fault_count < MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        fault_count++;
    endtask

    function automatic logic [7:0] scale_byte(input logic [7:0] a, input logic [7:0] b);
        logic [16:0] t;
        t = a * b + 17'd128;
        t = t + (t >> 8);
        return t[15:8];
    endfunction

    function automatic logic cmp_holds(input logic [2:0] fn, input logic [23:0] x,
                                       input logic [23:0] r);
        logic res;
        case (fn)
            CMP_NEVER:  res = 1'b0;
            CMP_LT:     res = x < r;
            CMP_EQ:     res = x == r;
            CMP_LE:     res = x <= r;
            CMP_GT:     res = x > r;
            CMP_NE:     res = x != r;
            CMP_GE:     res = x >= r;
            default:    res = 1'b1;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] combined_alpha(input logic [47:0] corners,
                                                  input logic [7:0] ta, input logic [7:0] va);
        longint k0, k1, k2, k3, t, v, n, q;
        k0 = $signed(corners[11:0]);
        k1 = $signed(corners[23:12]);
        k2 = $signed(corners[35:24]);
        k3 = $signed(corners[47:36]);
        t = ta;
        v = va;
        n = k0 * (255 - t) * (255 - v) + k1 * t * (255 - v)
          + k2 * (255 - t) * v + k3 * t * v;
        if (n <= 0)
            return 8'd0;
        q = (2 * n + COMBINE_DIV) / (2 * COMBINE_DIV);
        return (q > 255) ? 8'hFF : q[7:0];
    endfunction

    function automatic t_out_res shade_fragment(input t_cfg c, input t_in_req r);
        t_out_res    res;
        logic [31:0] src;
        logic [31:0] colour;
        logic [7:0]  sa;
        logic [7:0]  inv;
        logic [8:0]  sum;
        logic        first_ok;
        logic        second_ok;
        logic        passed;
        int          k;
        res = '0;
        colour = '0;
        for (k = 0; k < 3; k++)
            src[8*k +: 8] = scale_byte(r.texel_color[8*k +: 8],
                                       (k == 0) ? r.vertex_red :
                                       (k == 1) ? r.vertex_green : r.vertex_blue);
        if (c.alpha_combine_enable)
            sa = combined_alpha(c.alpha_combine_corners, r.texel_color[31:24], r.vertex_alpha);
        else
            sa = scale_byte(r.texel_color[31:24], r.vertex_alpha);
        src[31:24] = sa;

        first_ok  = cmp_holds(c.alpha_compare_first, sa, c.alpha_references[7:0]);
        second_ok = cmp_holds(c.alpha_compare_second, sa, c.alpha_references[15:8]);
        case (c.alpha_join)
            LOGIC_AND: passed = first_ok & second_ok;
            LOGIC_OR:  passed = first_ok | second_ok;
            LOGIC_XOR: passed = first_ok ^ second_ok;
            default:   passed = first_ok ~^ second_ok;
        endcase

        res.new_depth = r.fragment_depth;
        if (!passed) begin
            res.alpha_killed = 1'b1;
        end else begin
            if (c.depth_control[DEPTH_TEST_BIT]) begin
                if (!cmp_holds(c.depth_control[4:2], r.fragment_depth, r.dest_depth))
                    res.depth_killed = 1'b1;
                else if (c.depth_control[DEPTH_WRITE_BIT])
                    res.depth_write_enable = 1'b1;
            end
            if (!res.depth_killed) begin
                case (c.blend_mode)
                    BLEND_OPAQUE: begin
                        colour = src;
                        res.color_write_enable = 1'b1;
                    end
                    BLEND_ADD: begin
                        for (k = 0; k < 3; k++) begin
                            sum = r.dest_color[8*k +: 8] + scale_byte(src[8*k +: 8], sa);
                            colour[8*k +: 8] = sum[8] ? BYTE_MAX : sum[7:0];
                        end
                        sum = r.dest_color[31:24] + sa;
                        colour[31:24] = sum[8] ? BYTE_MAX : sum[7:0];
                        res.color_write_enable = 1'b1;
                    end
                    default: begin
                        if (sa != 8'd0) begin
                            if (sa == BYTE_MAX) begin
                                colour = src;
                            end else begin
                                inv = BYTE_MAX - sa;
                                for (k = 0; k < 3; k++)
                                    colour[8*k +: 8] = scale_byte(src[8*k +: 8], sa)
                                                     + scale_byte(r.dest_color[8*k +: 8], inv);
                                colour[31:24] = sa + scale_byte(r.dest_color[31:24], inv);
                            end
                            res.color_write_enable = 1'b1;
                        end
                    end
                endcase
            end
        end
        res.new_color = colour;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_res_valid !== 1'b0) begin
                if (pending_pixels.size() == 0) begin
                    report_mismatch("pixel with no fragment waiting", 64'(o_res), 64'd0);
                end else begin
                    expected_pixel = pending_pixels.pop_front();
                    pixels_checked++;
                    if (o_res.alpha_killed !== expected_pixel.alpha_killed)
                        report_mismatch("alpha_killed", 64'(o_res.alpha_killed),
                                        64'(expected_pixel.alpha_killed));
                    if (o_res.depth_killed !== expected_pixel.depth_killed)
                        report_mismatch("depth_killed", 64'(o_res.depth_killed),
                                        64'(expected_pixel.depth_killed));
                    if (o_res.depth_write_enable !== expected_pixel.depth_write_enable)
                        report_mismatch("depth_write_enable", 64'(o_res.depth_write_enable),
                                        64'(expected_pixel.depth_write_enable));
                    if (o_res.new_depth !== expected_pixel.new_depth)
                        report_mismatch("new_depth", 64'(o_res.new_depth),
                                        64'(expected_pixel.new_depth));
                    if (o_res.color_write_enable !== expected_pixel.color_write_enable)
                        report_mismatch("color_write_enable", 64'(o_res.color_write_enable),
                                        64'(expected_pixel.color_write_enable));
                    if (o_res.new_color !== expected_pixel.new_color)
                        report_mismatch("new_color", 64'(o_res.new_color),
                                        64'(expected_pixel.new_color));
                end
            end
            if (start && !busy) begin
                pending_pixels.push_back(shade_fragment(raster_cfg, i_req));
                fragments_sent++;
            end
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] idx, output logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 3'b000};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        value = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [63:0] reg_value(input t_cfg c, input logic [2:0] idx);
        logic [63:0] v;
        v = '0;
        case (idx)
            REG_ALPHA_CMP_FIRST:  v[2:0]  = c.alpha_compare_first;
            REG_ALPHA_CMP_SECOND: v[2:0]  = c.alpha_compare_second;
            REG_ALPHA_JOIN:       v[1:0]  = c.alpha_join;
            REG_ALPHA_REFS:       v[15:0] = c.alpha_references;
            REG_DEPTH_CONTROL:    v[4:0]  = c.depth_control;
            REG_BLEND_MODE:       v[1:0]  = c.blend_mode;
            REG_COMBINE_ENABLE:   v[0]    = c.alpha_combine_enable;
            default:              v[47:0] = c.alpha_combine_corners;
        endcase
        return v;
    endfunction

    task automatic apply_config(input t_cfg c);
        int idx;
        for (idx = REG_ALPHA_CMP_FIRST; idx <= REG_COMBINE_CORNERS; idx++)
            apb_write(3'(idx), reg_value(c, 3'(idx)));
        raster_cfg = c;
        settings_applied++;
    endtask

    task automatic check_registers();
        int          idx;
        logic [63:0] got;
        for (idx = REG_ALPHA_CMP_FIRST; idx <= REG_COMBINE_CORNERS; idx++) begin
            apb_read(3'(idx), got);
            if (got !== reg_value(raster_cfg, 3'(idx)))
                report_mismatch("register readback", got, reg_value(raster_cfg, 3'(idx)));
        end
    endtask

    task automatic send_fragment(input t_in_req r);
        int seen;
        seen  = fragments_sent;
        i_req = r;
        start = 1'b1;
        do @(negedge i_clk); while (fragments_sent == seen);
    endtask

    task automatic drain_pixels();
        int spin;
        start = 1'b0;
        for (spin = 0; spin < DRAIN_LIMIT && pending_pixels.size() != 0; spin++)
            @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
        if (pending_pixels.size() != 0) begin
            report_mismatch("pixels never returned", 64'(pending_pixels.size()), 64'd0);
            pending_pixels.delete();
        end
    endtask

    function automatic t_in_req make_fragment(input logic [31:0] tex, input logic [7:0] vr,
                                              input logic [7:0] vg, input logic [7:0] vb,
                                              input logic [7:0] va, input logic [23:0] z,
                                              input logic [31:0] dst, input logic [23:0] zs);
        return '{tex, vr, vg, vb, va, z, dst, zs};
    endfunction

    function automatic t_cfg base_config();
        t_cfg c;
        c = '0;
        c.alpha_compare_first  = CMP_ALWAYS;
        c.alpha_compare_second = CMP_ALWAYS;
        c.alpha_join           = LOGIC_AND;
        c.blend_mode           = BLEND_OPAQUE;
        return c;
    endfunction

    function automatic logic [4:0] depth_setting(input logic [2:0] fn, input logic wr,
                                                 input logic en);
        return {fn, wr, en};
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return BYTE_MAX;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(7))
            0:       return '1;
            1:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_req random_fragment();
        t_in_req r;
        r.texel_color  = random_word();
        r.vertex_red   = random_byte();
        r.vertex_green = random_byte();
        r.vertex_blue  = random_byte();
        r.vertex_alpha = random_byte();
        case ($urandom_range(7))
            0:       r.fragment_depth = '0;
            1:       r.fragment_depth = MAX_DEPTH;
            default: r.fragment_depth = 24'($urandom);
        endcase
        case ($urandom_range(5))
            0, 1:    r.dest_depth = r.fragment_depth;
            2:       r.dest_depth = r.fragment_depth + 24'd1;
            3:       r.dest_depth = r.fragment_depth - 24'd1;
            default: r.dest_depth = 24'($urandom);
        endcase
        r.dest_color = random_word();
        return r;
    endfunction

    function automatic t_cfg random_config();
        t_cfg        c;
        logic [11:0] corner;
        int          k;
        c.alpha_compare_first  = 3'($urandom_range(7));
        c.alpha_compare_second = 3'($urandom_range(7));
        c.alpha_join           = 2'($urandom_range(3));
        if ($urandom_range(2) == 0) begin
            c.alpha_compare_first = CMP_ALWAYS;
            c.alpha_join          = LOGIC_OR;
        end
        c.alpha_references     = 16'($urandom);
        c.depth_control        = 5'($urandom);
        c.blend_mode           = 2'($urandom_range(3));
        c.alpha_combine_enable = 1'($urandom_range(1));
        for (k = 0; k < 4; k++) begin
            case ($urandom_range(3))
                0:       corner = 12'($urandom);
                1:       corner = 12'($urandom_range(300));
                2:       corner = 12'd0 - 12'($urandom_range(64));
                default: corner = $urandom_range(1) ? 12'h7FF : 12'h800;
            endcase
            c.alpha_combine_corners[12*k +: 12] = corner;
        end
        return c;
    endfunction

    task automatic test_register_access();
        check_registers();
        apply_config('1);
        check_registers();
        apply_config('0);
        check_registers();
    endtask

    task automatic test_modulate();
        apply_config(base_config());
        send_fragment(make_fragment('0, BYTE_MAX, BYTE_MAX, BYTE_MAX, BYTE_MAX,
                                    '0, '0, '0));
        send_fragment(make_fragment('1, BYTE_MAX, BYTE_MAX, BYTE_MAX, BYTE_MAX,
                                    MAX_DEPTH, '1, MAX_DEPTH));
        send_fragment(make_fragment(32'hC0FF4080, 8'h00, 8'h80, 8'hFF, 8'h7F,
                                    24'h123456, 32'h5A5AA5A5, 24'h654321));
        drain_pixels();
    endtask

    task automatic test_alpha_test();
        t_cfg c;
        int   f;
        for (f = CMP_NEVER; f <= CMP_ALWAYS; f++) begin
            c = base_config();
            c.alpha_compare_first  = 3'(f);
            c.alpha_compare_second = 3'(CMP_ALWAYS - f);
            c.alpha_join           = 2'(f);
            c.alpha_references     = {8'h40, 8'h80};
            apply_config(c);
            send_fragment(make_fragment('1, 8'h11, 8'h22, 8'h33, 8'h7F + 8'(f % 3),
                                        24'h000100, 32'h01020304, 24'h000200));
            drain_pixels();
        end
    endtask

    task automatic test_depth();
        t_cfg c;
        c = base_config();
        c.depth_control = depth_setting(CMP_LT, 1'b1, 1'b1);
        apply_config(c);
        send_fragment(make_fragment('1, 8'h80, 8'h80, 8'h80, BYTE_MAX, '0, '0, MAX_DEPTH));
        send_fragment(make_fragment('1, 8'h80, 8'h80, 8'h80, BYTE_MAX,
                                    MAX_DEPTH, '0, MAX_DEPTH));
        send_fragment(make_fragment('1, 8'h80, 8'h80, 8'h80, BYTE_MAX, MAX_DEPTH, '0, '0));
        drain_pixels();

        // write enable alone must not store depth
        c.depth_control = depth_setting(CMP_GE, 1'b1, 1'b0);
        apply_config(c);
        send_fragment(make_fragment('1, 8'h40, 8'h40, 8'h40, BYTE_MAX, '0, '0, MAX_DEPTH));
        drain_pixels();

        c.alpha_compare_first = CMP_NEVER;
        c.depth_control       = depth_setting(CMP_NEVER, 1'b1, 1'b1);
        apply_config(c);
        send_fragment(make_fragment('1, 8'h40, 8'h40, 8'h40, BYTE_MAX, 24'h10, '0, 24'h20));
        drain_pixels();
    endtask

    task automatic test_blend();
        t_cfg c;
        c = base_config();
        c.depth_control = depth_setting(CMP_ALWAYS, 1'b1, 1'b1);
        c.blend_mode    = BLEND_ADD;
        apply_config(c);
        send_fragment(make_fragment('1, BYTE_MAX, BYTE_MAX, BYTE_MAX, BYTE_MAX,
                                    24'h000444, 32'h80402010, 24'h000555));
        drain_pixels();

        c.blend_mode = BLEND_OVER;
        apply_config(c);
        // transparent source still writes depth
        send_fragment(make_fragment('1, 8'h90, 8'hA0, 8'hB0, 8'h00,
                                    24'h0ABCDE, 32'h11223344, 24'h0FFFFF));
        send_fragment(make_fragment('1, 8'h90, 8'hA0, 8'hB0, BYTE_MAX,
                                    24'h0ABCDE, 32'h11223344, 24'h0FFFFF));
        send_fragment(make_fragment(32'hFFC08040, 8'hF0, 8'hE0, 8'hD0, 8'h80,
                                    24'h0ABCDE, 32'h7F3FBF1F, 24'h0FFFFF));
        drain_pixels();

        c.blend_mode = BLEND_OVER_ALT;
        apply_config(c);
        send_fragment(make_fragment(32'hFF8040C0, 8'hC0, 8'h60, 8'h30, 8'h60,
                                    24'h000001, 32'hE0D0C0B0, 24'h000002));
        drain_pixels();
    endtask

    task automatic test_alpha_combine();
        t_cfg c;
        c = base_config();
        c.alpha_combine_enable  = 1'b1;
        c.alpha_combine_corners = {4{12'h7FF}};
        apply_config(c);
        send_fragment(make_fragment(32'h80FFFFFF, 8'h80, 8'h80, 8'h80, 8'h40,
                                    24'h1, 32'h0, 24'h2));
        drain_pixels();

        c.alpha_combine_corners = {4{12'h800}};
        apply_config(c);
        send_fragment(make_fragment(32'h80FFFFFF, 8'h80, 8'h80, 8'h80, 8'h40,
                                    24'h1, 32'h0, 24'h2));
        drain_pixels();

        c.alpha_combine_corners = {12'h100, 12'h080, 12'h040, 12'hFC0};
        apply_config(c);
        send_fragment(make_fragment(32'h90FFFFFF, 8'hFF, 8'h00, 8'h80, 8'h70,
                                    24'h1, 32'h0, 24'h2));
        drain_pixels();
    endtask

    task automatic test_random_traffic();
        t_cfg c;
        int   phase;
        int   n;
        bit   idling;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0)
                c = '0;
            else if (phase == 1)
                c = '1;
            else
                c = random_config();
            apply_config(c);
            idling = !(phase == CALM_PHASE || phase == CALM_PHASE + 1);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (idling && $urandom_range(99) < IDLE_PERCENT) begin
                    start = 1'b0;
                    repeat ($urandom_range(1, 3)) @(negedge i_clk);
                end
                send_fragment(random_fragment());
            end
            drain_pixels();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_access();
        test_modulate();
        test_alpha_test();
        test_depth();
        test_blend();
        test_alpha_combine();
        test_random_traffic();

        $display("Covered %0d fragments, %0d pixels checked, %0d register settings applied",
                 fragments_sent, pixels_checked, settings_applied);
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * WATCHDOG_CYCLES);
        $display("Timed out with %0d pixels outstanding", pending_pixels.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
src/ftb_pkg.sv
src/ftb_regs.sv
src/ftb_src.sv
src/ftb_rop.sv
src/fragment_test_and_blend_unit.sv
tb/tb_fragment_test_and_blend_unit.sv
